[rtl/core/gbts_pkg.sv]
// Shared types and codes for the gap buffer text store.
package gbts_pkg;

   localparam int ACTION_W = 3;
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 11;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BACKSPACE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_MOVE      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic exec;      // item accepted this cycle
      logic rd_done;   // read data ready, load result
      logic mv_rd;     // fetch one byte of a gap move
      logic mv_wr;     // store it across the gap
      logic mv_done;   // gap at target, load result
   } gbts_cmd_type;

   typedef struct packed {
      logic out_free;
      logic read_ok;
      logic move_ok;
      logic at_target;
   } gbts_stat_type;

endpackage

[rtl/core/gbts_if.sv]
// Request and response channel interfaces.
interface gbts_req_if import gbts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   data_char;
   logic [POS_W-1:0]    position;

   modport source (output valid, action, data_char, position, input ready);
   modport sink (input valid, action, data_char, position, output ready);
endinterface

interface gbts_rsp_if import gbts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CHAR_W-1:0]   read_char;
   logic [POS_W-1:0]    text_length;
   logic [POS_W-1:0]    cursor;

   modport source (output valid, status, read_char, text_length, cursor, input ready);
   modport sink (input valid, status, read_char, text_length, cursor, output ready);
endinterface

[rtl/core/gbts_ctrl.sv]
// Sequencing state machine for the gap buffer text store.
module gbts_ctrl import gbts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   input  gbts_stat_type       stat,
   output gbts_cmd_type        cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RDWAIT = 2'd1;
   localparam logic [1:0] S_MVCHK  = 2'd2;
   localparam logic [1:0] S_MVWR   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE) && stat.out_free;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.exec = 1'b1;
               if (req_action == ACT_READ && stat.read_ok) begin
                  state_in = S_RDWAIT;
               end else if (req_action == ACT_MOVE && stat.move_ok) begin
                  state_in = S_MVCHK;
               end
            end
         end
         S_RDWAIT: begin
            cmd.rd_done = 1'b1;
            state_in    = S_IDLE;
         end
         S_MVCHK: begin
            if (stat.at_target) begin
               cmd.mv_done = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.mv_rd = 1'b1;
               state_in  = S_MVWR;
            end
         end
         S_MVWR: begin
            cmd.mv_wr = 1'b1;
            state_in  = S_MVCHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/gbts_datapath.sv]
// Gap pointers, text memory and result register.
module gbts_datapath import gbts_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [CHAR_W-1:0]   req_data_char,
   input  logic [POS_W-1:0]    req_position,
   input  gbts_cmd_type        cmd,
   output gbts_stat_type       stat,
   gbts_rsp_if.source          rsp_ch
);

   localparam int AW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = (AW > POS_W) ? AW : POS_W;
   localparam logic [AW-1:0] CAP = AW'(CAPACITY);

   logic [CHAR_W-1:0] mem [CAPACITY];

   logic [AW-1:0]       gs_ff, gs_in, ge_ff, ge_in, target_ff, target_in;
   logic [AW-1:0]       gs_inc, gs_dec, ge_inc, ge_dec, gap, len, pos_a, rd_addr;
   logic [CW-1:0]       pos_cw, len_cw, len_out_cw, cur_out_cw;
   logic                dir_ff, dir_in, down;
   logic                we, re, load_exec, load_out;
   logic [IW-1:0]       waddr, raddr;
   logic [CHAR_W-1:0]   wdata, rdata_ff;
   logic [STATUS_W-1:0] st;
   logic [AW-1:0]       len_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [POS_W-1:0]    rsp_len_ff, rsp_cur_ff;

   assign gs_inc  = gs_ff + AW'(1);
   assign gs_dec  = gs_ff - AW'(1);
   assign ge_inc  = ge_ff + AW'(1);
   assign ge_dec  = ge_ff - AW'(1);
   assign gap     = ge_ff - gs_ff;
   assign len     = CAP - gap;
   assign pos_cw  = CW'(req_position);
   assign len_cw  = CW'(len);
   assign pos_a   = AW'(pos_cw);
   assign rd_addr = (pos_a < gs_ff) ? pos_a : pos_a + gap;
   assign down    = gs_ff > target_ff;

   assign stat.out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign stat.read_ok   = pos_cw < len_cw;
   assign stat.move_ok   = pos_cw <= len_cw;
   assign stat.at_target = gs_ff == target_ff;

   always_comb begin
      gs_in     = gs_ff;
      ge_in     = ge_ff;
      target_in = target_ff;
      dir_in    = dir_ff;
      we        = 1'b0;
      waddr     = gs_ff[IW-1:0];
      wdata     = req_data_char;
      st        = ST_OK;
      load_exec = 1'b0;
      if (cmd.exec) begin
         load_exec = 1'b1;
         case (req_action)
            ACT_INSERT: begin
               if (gs_ff == ge_ff) begin
                  st = ST_FULL;
               end else begin
                  we    = 1'b1;
                  gs_in = gs_inc;
               end
            end
            ACT_DELETE: begin
               if (ge_ff == CAP) st = ST_EMPTY;
               else ge_in = ge_inc;
            end
            ACT_BACKSPACE: begin
               if (gs_ff == '0) st = ST_EMPTY;
               else gs_in = gs_dec;
            end
            ACT_MOVE: begin
               if (!stat.move_ok) begin
                  st = ST_RANGE;
               end else begin
                  load_exec = 1'b0;
                  target_in = pos_a;
               end
            end
            ACT_READ: begin
               if (!stat.read_ok) st = ST_RANGE;
               else load_exec = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (cmd.mv_rd) begin
         dir_in = down;
      end else if (cmd.mv_wr) begin
         we    = 1'b1;
         wdata = rdata_ff;
         if (dir_ff) begin
            waddr = ge_dec[IW-1:0];
            gs_in = gs_dec;
            ge_in = ge_dec;
         end else begin
            gs_in = gs_inc;
            ge_in = ge_inc;
         end
      end
   end

   // down move copies the byte before the gap to the gap's last slot
   assign raddr = cmd.mv_rd ? (down ? gs_dec[IW-1:0] : ge_ff[IW-1:0]) : rd_addr[IW-1:0];
   assign re    = cmd.mv_rd || (cmd.exec && req_action == ACT_READ && stat.read_ok);

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
   end

   assign load_out     = load_exec || cmd.rd_done || cmd.mv_done;
   assign len_in       = CAP - (ge_in - gs_in);
   assign len_out_cw   = CW'(len_in);
   assign cur_out_cw   = CW'(gs_in);
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff        <= '0;
         ge_ff        <= CAP;
         rsp_valid_ff <= 1'b0;
      end else begin
         gs_ff        <= gs_in;
         ge_ff        <= ge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      dir_ff    <= dir_in;
      if (load_out) begin
         rsp_status_ff <= load_exec ? st : ST_OK;
         rsp_char_ff   <= cmd.rd_done ? rdata_ff : '0;
         rsp_len_ff    <= len_out_cw[POS_W-1:0];
         rsp_cur_ff    <= cur_out_cw[POS_W-1:0];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_char   = rsp_char_ff;
   assign rsp_ch.text_length = rsp_len_ff;
   assign rsp_ch.cursor      = rsp_cur_ff;

`ifndef NO_ASSERTIONS
   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gs_ff <= ge_ff) else $error("gap start past gap end");
   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      ge_ff <= CAP) else $error("gap end past capacity");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !load_out) else $error("result overwritten");
   a_move_dir: assert property (@(posedge clock) disable iff (reset)
      cmd.mv_wr |-> (dir_ff ? (gs_ff > target_ff) : (gs_ff < target_ff)))
      else $error("gap move steps away from target");
   a_move_len: assert property (@(posedge clock) disable iff (reset)
      cmd.mv_wr |=> (len == $past(len))) else $error("gap move changed length");
`endif

endmodule

[rtl/core/gap_buffer_text_store.sv]
// Top level of the gap buffer text store.
// Holds up to CAPACITY text bytes in one memory with a gap at the cursor and
// returns one result item per request item. Insert, delete, backspace, errors
// and unused codes finish in the accepting cycle, one item per clock if the
// result register is free. A read has a wait state as the memory read data
// is registered. A cursor move copies bytes across the gap one by one,
// one memory read and one memory write per byte. A request is taken when idle
// and the output register is empty or draining. No clearing pass after reset.
module gap_buffer_text_store import gbts_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input logic        clock,
   input logic        reset,
   gbts_req_if.sink   req_ch,
   gbts_rsp_if.source rsp_ch
);

   gbts_cmd_type  cmd;
   gbts_stat_type stat;

   gbts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gbts_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_ch.action),
      .req_data_char (req_ch.data_char),
      .req_position  (req_ch.position),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ch        (rsp_ch)
   );

endmodule

[dv/gap_buffer_text_store_tb.sv]
`timescale 1ns / 1ps
// Testbench for the gap buffer text store: random and directed edits checked against a byte model.
module gap_buffer_text_store_tb;
   import gbts_pkg::*;

   localparam int TEXT_CAP    = 1024;
   localparam int TIDX_W      = $clog2(TEXT_CAP);
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 10000;
   localparam int RANDOM_ITEMS = 300;

   localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHAR_W-1:0]   read_char;
      logic [POS_W-1:0]    text_length;
      logic [POS_W-1:0]    cursor;
   } edit_result_type;

   logic clock;
   logic reset;

   gbts_req_if req_ch();
   gbts_rsp_if rsp_ch();

   gap_buffer_text_store #(.CAPACITY(TEXT_CAP)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [CHAR_W-1:0] text_mem [TEXT_CAP];
   int unsigned       gap_lo = 0;
   int unsigned       gap_hi = TEXT_CAP;
   edit_result_type   pending_results[$];
   int                error_count = 0;
   int                rsp_count = 0;
   bit                idle_off = 1'b0;
   bit                rsp_hold_req = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   function automatic int unsigned text_length_now();
      return TEXT_CAP - (gap_hi - gap_lo);
   endfunction

   function automatic logic [TIDX_W-1:0] tidx(input int unsigned i);
      return i[TIDX_W-1:0];
   endfunction

   // Applies one edit to the byte model and returns the result it produces.
   function automatic edit_result_type apply_edit(input logic [ACTION_W-1:0] act,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [POS_W-1:0] pos);
      edit_result_type r;
      int unsigned     target;
      int unsigned     len;
      r = '0;
      r.status = ST_OK;
      target = 32'(pos);
      case (act)
         ACT_INSERT: begin
            if (gap_lo >= gap_hi) begin
               r.status = ST_FULL;
            end else begin
               text_mem[tidx(gap_lo)] = ch;
               gap_lo++;
            end
         end
         ACT_DELETE: begin
            if (gap_hi >= TEXT_CAP) r.status = ST_EMPTY;
            else gap_hi++;
         end
         ACT_BACKSPACE: begin
            if (gap_lo == 0) r.status = ST_EMPTY;
            else gap_lo--;
         end
         ACT_MOVE: begin
            if (target > text_length_now()) begin
               r.status = ST_RANGE;
            end else begin
               while (gap_lo > target) begin
                  gap_lo--;
                  gap_hi--;
                  text_mem[tidx(gap_hi)] = text_mem[tidx(gap_lo)];
               end
               while (gap_lo < target && gap_hi < TEXT_CAP) begin
                  text_mem[tidx(gap_lo)] = text_mem[tidx(gap_hi)];
                  gap_lo++;
                  gap_hi++;
               end
            end
         end
         ACT_READ: begin
            if (target >= text_length_now()) r.status = ST_RANGE;
            else if (target < gap_lo) r.read_char = text_mem[tidx(target)];
            else r.read_char = text_mem[tidx(target + (gap_hi - gap_lo))];
         end
         default: ;
      endcase
      len = text_length_now();
      r.text_length = len[POS_W-1:0];
      r.cursor = gap_lo[POS_W-1:0];
      return r;
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act,
                            input logic [CHAR_W-1:0] ch,
                            input logic [POS_W-1:0] pos);
      int gap;
      if (!idle_off && $urandom_range(99) < 7) begin
         gap = $urandom_range(1, 2);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.data_char <= ch;
      req_ch.position  <= pos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(apply_edit(act, ch, pos));
   endtask

   function automatic logic [POS_W-1:0] pick_position(input int unsigned len);
      int unsigned r;
      int unsigned p;
      r = $urandom_range(99);
      if (r < 6) p = $urandom_range(2047);
      else if (r < 12) p = len;
      else if (r < 16) p = 0;
      else if (r < 20) p = (len > 0) ? len - 1 : 0;
      else p = $urandom_range(len);
      return p[POS_W-1:0];
   endfunction

   task automatic send_random_edit(input int unsigned ins_pct);
      int unsigned       r;
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] ch;
      r = $urandom_range(99);
      pos = pick_position(text_length_now());
      ch = CHAR_W'($urandom_range(255));
      if (r < ins_pct) send_item(ACT_INSERT, ch, pos);
      else if (r < ins_pct + 12) send_item(ACT_DELETE, ch, pos);
      else if (r < ins_pct + 24) send_item(ACT_BACKSPACE, ch, pos);
      else if (r < ins_pct + 40) send_item(ACT_MOVE, ch, pos);
      else if (r < 97) send_item(ACT_READ, ch, pos);
      else begin
         case ($urandom_range(2))
            0: send_item(ACT_SPARE_5, ch, pos);
            1: send_item(ACT_SPARE_6, ch, pos);
            default: send_item(ACT_SPARE_7, ch, pos);
         endcase
      end
   endtask

   task automatic test_empty_store();
      send_item(ACT_DELETE, 8'h00, 11'd0);
      send_item(ACT_BACKSPACE, 8'hFF, 11'h7FF);
      send_item(ACT_READ, 8'h00, 11'd0);
      send_item(ACT_MOVE, 8'h00, 11'd1);
      send_item(ACT_MOVE, 8'h00, 11'd0);
      send_item(ACT_MOVE, 8'h00, 11'h7FF);
      send_item(ACT_READ, 8'h00, 11'd1024);
      send_item(ACT_SPARE_5, 8'hFF, 11'h7FF);
      send_item(ACT_SPARE_6, 8'h00, 11'd0);
      send_item(ACT_SPARE_7, 8'hA5, 11'd1024);
   endtask

   task automatic test_basic_edits();
      send_item(ACT_INSERT, 8'h00, 11'd0);
      send_item(ACT_INSERT, 8'hFF, 11'h7FF);
      send_item(ACT_INSERT, 8'hA5, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd2);
      send_item(ACT_READ, 8'h00, 11'd3);
      send_item(ACT_MOVE, 8'h00, 11'd0);
      send_item(ACT_INSERT, 8'h5A, 11'd0);
      send_item(ACT_MOVE, 8'h00, 11'd3);
      send_item(ACT_DELETE, 8'h00, 11'd0);
      send_item(ACT_BACKSPACE, 8'h00, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd1);
      send_item(ACT_MOVE, 8'h00, 11'd2);
   endtask

   task automatic test_random_edits();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_off = (i < 100);
         send_random_edit((text_length_now() > 300) ? 15 : 35);
      end
      idle_off = 1'b0;
   endtask

   task automatic test_output_stall();
      rsp_hold_req = 1'b1;
      repeat (40) send_random_edit(35);
   endtask

   task automatic test_full_store();
      int unsigned r;
      send_item(ACT_MOVE, 8'h00, pick_position(text_length_now()));
      while (text_length_now() < TEXT_CAP) begin
         if ($urandom_range(99) < 5)
            send_item(ACT_READ, 8'h00, pick_position(text_length_now()));
         else
            send_item(ACT_INSERT, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
      end
      send_item(ACT_INSERT, 8'hFF, 11'd0);
      send_item(ACT_INSERT, 8'h00, 11'h7FF);
      send_item(ACT_READ, 8'h00, 11'd0);
      send_item(ACT_READ, 8'h00, 11'd1023);
      send_item(ACT_READ, 8'h00, 11'd1024);
      send_item(ACT_MOVE, 8'h00, 11'd1024);
      send_item(ACT_INSERT, 8'h3C, 11'd0);
      send_item(ACT_MOVE, 8'h00, 11'd1025);
      send_item(ACT_MOVE, 8'h00, 11'd0);
      send_item(ACT_BACKSPACE, 8'h00, 11'd0);
      send_item(ACT_DELETE, 8'h00, 11'd0);
      send_item(ACT_INSERT, 8'h5A, 11'd0);
      send_item(ACT_MOVE, 8'h00, 11'd1024);
      send_item(ACT_DELETE, 8'h00, 11'd0);
      send_item(ACT_BACKSPACE, 8'h00, 11'd0);
      send_item(ACT_INSERT, 8'hC3, 11'd0);
      send_item(ACT_MOVE, 8'h00, 11'd512);
      while (text_length_now() > TEXT_CAP - 128) begin
         r = $urandom_range(99);
         if (r < 45) send_item(ACT_DELETE, 8'h00, 11'd0);
         else if (r < 90) send_item(ACT_BACKSPACE, 8'h00, 11'd0);
         else if (r < 97)
            send_item(ACT_READ, 8'h00, pick_position(text_length_now()));
         else
            send_item(ACT_MOVE, 8'h00, pick_position(text_length_now()));
      end
      send_item(ACT_DELETE, 8'h00, 11'd0);
      send_item(ACT_BACKSPACE, 8'h00, 11'd0);
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= idle_off || ($urandom_range(99) >= 10);
         end
      end
   end

   always @(posedge clock) begin
      edit_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending", rsp_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, want %0d",
                                         rsp_count, rsp_ch.status, want.status));
            if (rsp_ch.read_char !== want.read_char)
               report_mismatch($sformatf("result %0d read_char %h, want %h",
                                         rsp_count, rsp_ch.read_char, want.read_char));
            if (rsp_ch.text_length !== want.text_length)
               report_mismatch($sformatf("result %0d text_length %0d, want %0d",
                                         rsp_count, rsp_ch.text_length, want.text_length));
            if (rsp_ch.cursor !== want.cursor)
               report_mismatch($sformatf("result %0d cursor %0d, want %0d",
                                         rsp_count, rsp_ch.cursor, want.cursor));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int wait_cycles;
      wait_cycles = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_INSERT;
      req_ch.data_char <= '0;
      req_ch.position  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_store();
      test_basic_edits();
      test_random_edits();
      test_output_stall();
      test_full_store();

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/core/gbts_pkg.sv
rtl/core/gbts_if.sv
rtl/core/gbts_ctrl.sv
rtl/core/gbts_datapath.sv
rtl/core/gap_buffer_text_store.sv
dv/gap_buffer_text_store_tb.sv
